FILE: sv/canseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canseq_pkg
// shared types and constants of the CAN sequence reassembler
// ----------------------------------------------------------------------------
package canseq_pkg;

    localparam int ID_W        = 11;
    localparam int BYTE_W      = 8;
    localparam int FRAME_BYTES = 8;
    localparam int DATA_W      = FRAME_BYTES * BYTE_W;
    localparam int LEN_BYTES   = 4;
    localparam int LEN_W       = LEN_BYTES * BYTE_W;
    localparam int MAX_BYTES   = 4096;
    localparam int REM_W       = $clog2(MAX_BYTES + 1);
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_W       = ID_W;
    localparam logic [ID_W-1:0] HEADER_MATCH_RST = '0;
    localparam logic [ID_W-1:0] HEADER_MASK_RST  = '1;

    localparam int S_TDATA_W   = ((ID_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((DATA_W + CNT_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = ID_W + 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HEADER_MATCH = 1'b0,
        CFG_HEADER_MASK  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [DATA_W-1:0] frame_data;
    } t_item;

    typedef struct packed {
        logic              has;
        logic [ID_W-1:0]   message_type;
        logic [DATA_W-1:0] payload;
        logic [CNT_W-1:0]  valid_bytes;
        logic              last;
        logic              checksum_ok;
    } t_result;

endpackage

FILE: sv/canseq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canseq_core
// header matching, sequence state and per-frame payload extraction
// ----------------------------------------------------------------------------
module canseq_core
    import canseq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  t_item                 i_item,
    input  logic                  i_step,
    output t_result               o_res
);

    logic [ID_W-1:0]   r_match;
    logic [ID_W-1:0]   r_mask;
    logic              r_in_seq;
    logic [ID_W-1:0]   r_seq_type;
    logic [BYTE_W-1:0] r_exp_sum;
    logic [REM_W-1:0]  r_remaining;
    logic [BYTE_W-1:0] r_xor;

    logic              n_in_seq;
    logic [ID_W-1:0]   n_seq_type;
    logic [BYTE_W-1:0] n_exp_sum;
    logic [REM_W-1:0]  n_remaining;
    logic [BYTE_W-1:0] n_xor;

    logic              w_is_header;
    logic [LEN_W-1:0]  w_len;
    logic              w_len_ok;
    logic              w_is_last;
    logic [CNT_W-1:0]  w_count;
    logic [DATA_W-1:0] w_kept;
    logic [BYTE_W-1:0] w_xor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= HEADER_MATCH_RST;
            r_mask  <= HEADER_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_HEADER_MATCH: r_match <= i_cfg_wdata[ID_W-1:0];
                CFG_HEADER_MASK:  r_mask  <= i_cfg_wdata[ID_W-1:0];
            endcase
        end
    end

    always_comb begin
        w_is_header = (i_item.frame_id & r_mask) == (r_match & r_mask);
        w_len       = i_item.frame_data[BYTE_W +: LEN_W];
        w_len_ok    = w_len <= LEN_W'(MAX_BYTES);
        w_is_last   = r_remaining <= REM_W'(FRAME_BYTES);
        w_count     = w_is_last ? r_remaining[CNT_W-1:0] : CNT_W'(FRAME_BYTES);
        w_kept      = '0;
        w_xor       = r_xor;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            if (CNT_W'(k) < w_count) begin
                w_kept[k*BYTE_W +: BYTE_W] = i_item.frame_data[k*BYTE_W +: BYTE_W];
                w_xor = w_xor ^ i_item.frame_data[k*BYTE_W +: BYTE_W];
            end
        end
    end

    always_comb begin
        n_in_seq    = r_in_seq;
        n_seq_type  = r_seq_type;
        n_exp_sum   = r_exp_sum;
        n_remaining = r_remaining;
        n_xor       = r_xor;
        if (!r_in_seq) begin
            if (w_is_header && w_len_ok) begin
                n_in_seq    = 1'b1;
                n_seq_type  = i_item.frame_id;
                n_exp_sum   = i_item.frame_data[BYTE_W-1:0];
                n_remaining = w_len[REM_W-1:0];
                n_xor       = '0;
            end
        end else begin
            n_xor = w_xor;
            if (w_is_last) begin
                n_in_seq    = 1'b0;
                n_remaining = '0;
            end else begin
                n_remaining = r_remaining - REM_W'(FRAME_BYTES);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_seq <= 1'b0;
        end else if (i_step) begin
            r_in_seq <= n_in_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_seq_type  <= n_seq_type;
            r_exp_sum   <= n_exp_sum;
            r_remaining <= n_remaining;
            r_xor       <= n_xor;
        end
    end

    assign o_res.has          = r_in_seq;
    assign o_res.message_type = r_seq_type;
    assign o_res.payload      = w_kept;
    assign o_res.valid_bytes  = w_count;
    assign o_res.last         = w_is_last;
    assign o_res.checksum_ok  = w_is_last && (w_xor == r_exp_sum);

endmodule

FILE: sv/can_sequence_reassembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_sequence_reassembler
// reassembles multi-frame messages from received CAN frames
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one received frame per beat: identifier and eight bytes.
//   a frame matching the header pattern while idle opens a sequence: byte 0
//   is the expected xor checksum, bytes 1..4 the message length (little
//   endian, at most MAX_BYTES). headers and unmatched idle frames give no beat.
//   while a sequence is open every frame gives one m_axis beat with its
//   payload and the count of message bytes; tlast marks the final beat, whose
//   tuser checksum flag reports the xor check.
//   i_cfg_* writes the header match and mask registers; the user does so while
//   idle, which the block leaves to the user. frame and result are registered.
//   throughput: one frame per cycle while unstalled, set by the single-pass
//   update of the sequence state between the input and result registers.
//   reset: synchronous, clears both stages, closes any sequence and restores
//   match 0 and mask all ones.
//   stall: a held result stays on m_axis; frames that give no beat still pass,
//   and once a frame that gives a beat waits in the input register,
//   s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module can_sequence_reassembler
    import canseq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // frame_id, frame_data, zero pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // payload, valid_bytes, zero pad
    output logic [M_TUSER_W-1:0]  m_axis_tuser,   // message_type, checksum_ok
    output logic                  m_axis_tlast
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    t_result w_res;
    logic    w_out_free;
    logic    w_step;

    canseq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (r_in),
        .i_step      (w_step),
        .o_res       (w_res)
    );

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && (!w_res.has || w_out_free);
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.frame_id   <= s_axis_tdata[ID_W-1:0];
            r_in.frame_data <= s_axis_tdata[ID_W +: DATA_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step && w_res.has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_step && w_res.has) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - CNT_W){1'b0}},
                            r_out.valid_bytes, r_out.payload};
    assign m_axis_tuser  = {r_out.checksum_ok, r_out.message_type};
    assign m_axis_tlast  = r_out.last;

endmodule

FILE: sv/canseq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canseq_checker
// port-level checks of the CAN sequence reassembler result stream
// ----------------------------------------------------------------------------
module canseq_checker
    import canseq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser,
    input logic                 m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[DATA_W +: CNT_W] <= CNT_W'(FRAME_BYTES))
        else $error("valid byte count above frame size");

    a_full_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[DATA_W +: CNT_W] == CNT_W'(FRAME_BYTES))
        else $error("partial frame before end of message");

    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[ID_W] |-> m_axis_tlast)
        else $error("checksum flag on a beat that is not last");

endmodule

bind can_sequence_reassembler canseq_checker u_canseq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the CAN sequence reassembler: a queue-fed driver
// sends frames, a shadow model of the sequence state predicts every output
// beat, and a monitor compares each beat field by field, in order, under
// several header settings and several sender and receiver idle patterns
// ----------------------------------------------------------------------------
module tb_top;
    import canseq_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 3;
    localparam int SETTLE_GAP  = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 150;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = CFG_HEADER_MATCH;
    logic [CFG_W-1:0]     i_cfg_wdata    = '0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata   = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    can_sequence_reassembler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // frames waiting to be sent and beats waiting to come out
    t_item   pending_frames[$];
    t_result expected_beats[$];

    // shadow copy of the header registers and the sequence state
    logic [ID_W-1:0]   hdr_match = HEADER_MATCH_RST;
    logic [ID_W-1:0]   hdr_mask  = HEADER_MASK_RST;
    logic              seq_open  = 1'b0;
    logic [ID_W-1:0]   seq_type  = '0;
    logic [BYTE_W-1:0] seq_sum   = '0;
    logic [REM_W-1:0]  seq_left  = '0;
    logic [BYTE_W-1:0] seq_xor   = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int frames_in      = 0;
    int beats_out      = 0;
    int messages_done  = 0;
    int settings_used  = 0;
    bit frame_taken    = 1'b0;

    t_item   taken_frame;
    t_result sent_beat;
    t_result want_beat;
    t_result got_beat;

    function automatic t_result reassemble_frame(input t_item frm);
        t_result          beat;
        logic [LEN_W-1:0] len;
        logic [BYTE_W-1:0] b;
        int               n;
        beat = '0;
        if (!seq_open) begin
            if ((frm.frame_id & hdr_mask) == (hdr_match & hdr_mask)) begin
                len = frm.frame_data[BYTE_W +: LEN_W];
                if (len <= MAX_BYTES) begin
                    seq_open = 1'b1;
                    seq_type = frm.frame_id;
                    seq_sum  = frm.frame_data[BYTE_W-1:0];
                    seq_left = len[REM_W-1:0];
                    seq_xor  = '0;
                end
            end
        end else begin
            n = (seq_left > FRAME_BYTES) ? FRAME_BYTES : int'(seq_left);
            beat.has          = 1'b1;
            beat.message_type = seq_type;
            beat.valid_bytes  = n[CNT_W-1:0];
            beat.last         = (seq_left <= FRAME_BYTES);
            for (int k = 0; k < n; k++) begin
                b = frm.frame_data[k*BYTE_W +: BYTE_W];
                seq_xor = seq_xor ^ b;
                beat.payload[k*BYTE_W +: BYTE_W] = b;
            end
            seq_left = seq_left - n[REM_W-1:0];
            beat.checksum_ok = beat.last && (seq_xor == seq_sum);
            if (beat.last) begin
                seq_open = 1'b0;
                seq_left = '0;
            end
        end
        return beat;
    endfunction

    // input acceptance, prediction and output checking at the rising edge
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
                taken_frame = pending_frames.pop_front();
                sent_beat   = reassemble_frame(taken_frame);
                if (sent_beat.has)
                    expected_beats.push_back(sent_beat);
                frame_taken = 1'b1;
                frames_in++;
            end
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got_beat              = '0;
                got_beat.has          = 1'b1;
                got_beat.payload      = m_axis_tdata[DATA_W-1:0];
                got_beat.valid_bytes  = m_axis_tdata[DATA_W +: CNT_W];
                got_beat.message_type = m_axis_tuser[ID_W-1:0];
                got_beat.checksum_ok  = m_axis_tuser[ID_W];
                got_beat.last         = m_axis_tlast;
                beats_out++;
                if (expected_beats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("beat %0d with nothing expected: type %h payload %h n %0d",
                                 beats_out, got_beat.message_type, got_beat.payload,
                                 got_beat.valid_bytes);
                end else begin
                    want_beat = expected_beats.pop_front();
                    if (want_beat.last)
                        messages_done++;
                    if (got_beat.message_type != want_beat.message_type ||
                        got_beat.payload      != want_beat.payload ||
                        got_beat.valid_bytes  != want_beat.valid_bytes ||
                        got_beat.last         != want_beat.last ||
                        got_beat.checksum_ok  != want_beat.checksum_ok) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("beat %0d mismatch", beats_out);
                            $display("  exp type %h payload %h n %0d last %b ok %b",
                                     want_beat.message_type, want_beat.payload,
                                     want_beat.valid_bytes, want_beat.last,
                                     want_beat.checksum_ok);
                            $display("  got type %h payload %h n %0d last %b ok %b",
                                     got_beat.message_type, got_beat.payload,
                                     got_beat.valid_bytes, got_beat.last,
                                     got_beat.checksum_ok);
                        end
                    end
                end
            end
        end
    end

    // frame driver and receiver backpressure at the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (s_axis_tvalid && !frame_taken) begin
            // hold the current beat until it is taken
        end else if (i_rst_n && pending_frames.size() != 0 &&
                     $urandom_range(0, 99) >= send_idle_pct) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= S_TDATA_W'({pending_frames[0].frame_data,
                                         pending_frames[0].frame_id});
        end else begin
            s_axis_tvalid <= 1'b0;
        end
        frame_taken = 1'b0;
    end

    task automatic push_frame(input logic [ID_W-1:0] id, input logic [DATA_W-1:0] data);
        t_item frm;
        frm.frame_id   = id;
        frm.frame_data = data;
        pending_frames.push_back(frm);
    endtask

    task automatic set_headers(input logic [ID_W-1:0] match, input logic [ID_W-1:0] mask);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_HEADER_MATCH;
        i_cfg_wdata <= match;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_HEADER_MASK;
        i_cfg_wdata <= mask;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        hdr_match = match;
        hdr_mask  = mask;
        settings_used++;
    endtask

    // header plus payload frames; drop leaves the message short
    task automatic push_message(input logic [ID_W-1:0] hid, input int len,
                                input bit good_sum, input int drop);
        t_item             body[$];
        t_item             frm;
        logic [BYTE_W-1:0] sum;
        logic [LEN_W-1:0]  len_field;
        int                frames;
        int                n;
        sum       = '0;
        len_field = len;
        frames    = (len == 0) ? 1 : (len + FRAME_BYTES - 1) / FRAME_BYTES;
        for (int f = 0; f < frames; f++) begin
            frm.frame_id   = ID_W'($urandom_range(0, 2047));
            frm.frame_data = {$urandom, $urandom};
            n = len - f * FRAME_BYTES;
            if (n > FRAME_BYTES)
                n = FRAME_BYTES;
            for (int k = 0; k < n; k++)
                sum = sum ^ frm.frame_data[k*BYTE_W +: BYTE_W];
            body.push_back(frm);
        end
        if (!good_sum)
            sum = BYTE_W'($urandom_range(0, 255));
        push_frame(hid, {24'($urandom_range(0, 24'hFFFFFF)), len_field, sum});
        for (int f = 0; f < frames - drop; f++)
            pending_frames.push_back(body[f]);
    endtask

    function automatic logic [ID_W-1:0] header_id();
        logic [ID_W-1:0] noise;
        noise = ID_W'($urandom_range(0, 2047));
        return (hdr_match & hdr_mask) | (noise & ~hdr_mask);
    endfunction

    // send everything, close an open message, wait for all beats and a gap
    task automatic settle();
        while (pending_frames.size() != 0)
            @(negedge i_clk);
        while (seq_open) begin
            push_frame(ID_W'($urandom_range(0, 2047)), {$urandom, $urandom});
            while (pending_frames.size() != 0)
                @(negedge i_clk);
        end
        while (expected_beats.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_GAP) @(negedge i_clk);
    endtask

    initial begin
        int              r;
        int              len;
        int              count;
        logic [ID_W-1:0] match;
        logic [ID_W-1:0] mask;

        repeat (RESET_LEN) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        set_headers(11'h123, 11'h7FF);
        push_frame(11'h124, 64'h0);
        push_frame(11'h000, '1);
        push_frame(11'h123, {24'h0, 32'd4097, 8'h00});
        push_frame(11'h123, '1);
        push_message(11'h123, 0, 1'b1, 0);
        push_frame(11'h123, {24'h0, 32'd0, 8'h5A});
        push_frame(11'h7FF, '1);
        push_message(11'h123, 8, 1'b1, 0);
        push_frame(11'h123, {24'hABCDEF, 32'd9, 8'h00});
        push_frame(11'h123, 64'h0123_4567_89AB_CDEF);
        push_frame(11'h7FF, '1);
        push_message(11'h123, 3, 1'b0, 0);
        push_message(11'h123, 16, 1'b1, 0);
        settle();

        for (int ph = 1; ph <= 5; ph++) begin
            case (ph)
                1: begin match = '0;  mask = '1;  send_idle_pct = 0;  recv_stall_pct = 0;  end
                2: begin match = '1;  mask = '1;  send_idle_pct = 66; recv_stall_pct = 0;  end
                3: begin match = ID_W'($urandom_range(0, 2047)); mask = '0;
                         send_idle_pct = 0; recv_stall_pct = 66; end
                4: begin match = ID_W'($urandom_range(0, 2047));
                         mask = ID_W'($urandom_range(0, 2047));
                         send_idle_pct = 13; recv_stall_pct = 13; end
                default: begin match = '1; mask = 11'h700;
                         send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            set_headers(match, mask);
            count = 0;
            if (ph == 1) begin
                push_message(header_id(), MAX_BYTES, 1'b1, 0);
                count = 1 + MAX_BYTES / FRAME_BYTES;
            end
            while (count < PHASE_ITEMS) begin
                if (ph == 2 && count >= PHASE_ITEMS / 2 && count < PHASE_ITEMS / 2 + 4) begin
                    // sender holds off until the block has emptied
                    while (pending_frames.size() != 0 || expected_beats.size() != 0)
                        @(negedge i_clk);
                    count = PHASE_ITEMS / 2 + 4;
                end
                r = $urandom_range(0, 99);
                len = $urandom_range(0, 99);
                if (len < 80)
                    len = $urandom_range(0, 24);
                else if (len < 97)
                    len = $urandom_range(25, 200);
                else
                    len = $urandom_range(201, MAX_BYTES);
                if (r < 70) begin
                    push_message(header_id(), len, $urandom_range(0, 3) != 0, 0);
                    count += 2 + len / FRAME_BYTES;
                end else if (r < 80) begin
                    push_message(header_id(), len, 1'b1,
                                 $urandom_range(1, 1 + len / FRAME_BYTES));
                    count += 1 + len / FRAME_BYTES;
                end else if (r < 88) begin
                    push_frame(header_id(), {24'($urandom_range(0, 24'hFFFFFF)),
                               32'(MAX_BYTES + 1 + $urandom_range(0, 32'h7FFF_FFFF)),
                               8'($urandom_range(0, 255))});
                    count++;
                end else begin
                    push_frame(ID_W'($urandom_range(0, 2047)), {$urandom, $urandom});
                    count++;
                end
            end
            settle();
        end

        $display("frames sent %0d, beats checked %0d, messages closed %0d",
                 frames_in, beats_out, messages_done);
        $display("header settings %0d, with idle and stall patterns on both sides",
                 settings_used);
        if (fail_count == 0 && expected_beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures, %0d beats still expected", fail_count,
                     expected_beats.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
